### rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Widths, the pad character and the alphabet mapping functions shared by the
// Base64 codec and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package b64_pkg;

    localparam int SymW   = 8;
    localparam int SextW  = 6;
    localparam int GroupW = 24;
    localparam int CntW   = 2;
    localparam int LeftW  = 3;
    localparam int MaxRes = 4;

    localparam logic [SymW-1:0] PadChar   = 8'h3D;  // '='
    localparam logic [SymW-1:0] PlusChar  = 8'h2B;  // '+'
    localparam logic [SymW-1:0] SlashChar = 8'h2F;  // '/'

    // mode register codes
    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    // Map a sextet onto its character of the standard alphabet
    function automatic logic [SymW-1:0] sextet_to_char(input logic [SextW-1:0] v);
        logic [SymW-1:0] w;
        logic [SymW-1:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
            begin
                c = w + 8'd65;
            end
            else if (v < 6'd52)
            begin
                c = w + 8'd71;
            end
            else if (v < 6'd62)
            begin
                c = w - 8'd4;
            end
            else if (v == 6'd62)
            begin
                c = PlusChar;
            end
            else
            begin
                c = SlashChar;
            end
            return c;
        end
    endfunction

    // Map a character onto its sextet; anything outside the alphabet gives zero
    function automatic logic [SextW-1:0] char_to_sextet(input logic [SymW-1:0] c);
        logic [SymW-1:0] v;
        begin
            case (c) inside
                [8'h30:8'h39]: v = c + 8'd4;
                [8'h41:8'h5A]: v = c - 8'd65;
                [8'h61:8'h7A]: v = c - 8'd71;
                PlusChar:      v = 8'd62;
                SlashChar:     v = 8'd63;
                default:       v = 8'd0;
            endcase
            return v[SextW-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/b64_if.sv
// ----------------------------------------------------------------------------
// b64 channel interfaces
// Valid/ready channels for input items, result items and mode writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64_item_if;
    logic                      valid;
    logic                      ready;
    logic [b64_pkg::SymW-1:0]  symbol;
    logic                      last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface b64_result_if;
    logic                      valid;
    logic                      ready;
    logic [b64_pkg::SymW-1:0]  out_symbol;
    logic                      run_last;
    logic                      error;

    modport source (output valid, output out_symbol, output run_last, output error,
                    input ready);
    modport sink   (input valid, input out_symbol, input run_last, input error,
                    output ready);
endinterface

interface b64_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/base64_codec.sv
// ----------------------------------------------------------------------------
// base64_codec
// Streaming Base64 codec (standard alphabet, '=' padding). With mode 0 every
// three bytes become four characters and a final short group is padded; with
// mode 1 every four characters become three bytes, trimmed by the pad
// characters of the final group, and a stream ending mid-group yields a single
// result with error set, after which the whole stream must be dropped. Each
// accepted item passes through an input register and one step of logic into a
// four-entry result buffer that drains one word per cycle while results.ready is
// high. Decoding runs at one character per cycle under the same condition;
// encoding stalls the byte input while the four characters of each group leave
// the result buffer. A mode write clears any group in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_codec
(
    input  wire                 clk,
    input  wire                 rst_n,
    b64_cfg_if.sink             cfg,
    b64_item_if.sink            items,
    b64_result_if.source        results
);

    // input register
    logic                            item_valid_reg;
    logic [b64_pkg::SymW-1:0]        sym_reg;
    logic                            last_reg;

    // codec state
    b64_pkg::mode_t                  mode_reg;
    logic [b64_pkg::CntW-1:0]        count_reg;
    logic [b64_pkg::GroupW-1:0]      bits_reg;
    logic                            third_pad_reg;

    // result buffer
    logic [b64_pkg::SymW-1:0]        slot_reg [b64_pkg::MaxRes];
    logic [b64_pkg::LeftW-1:0]       left_reg;
    logic                            err_reg;

    // step results
    logic [b64_pkg::SymW-1:0]        res_sym [b64_pkg::MaxRes];
    logic [b64_pkg::LeftW-1:0]       res_n;
    logic                            res_err;
    logic [b64_pkg::CntW-1:0]        count_next;
    logic [b64_pkg::GroupW-1:0]      bits_next;
    logic                            third_pad_next;

    logic [b64_pkg::LeftW-1:0]       n;
    logic [b64_pkg::GroupW-1:0]      shifted;
    logic [b64_pkg::GroupW-1:0]      enc_t;
    logic                            out_take;
    logic                            slot_free;
    logic                            advance;
    logic                            cfg_take;

    // handshakes
    assign cfg.ready     = 1'b1;
    assign cfg_take      = cfg.valid;
    assign out_take      = results.valid && results.ready;
    assign slot_free     = (left_reg == '0) || (left_reg == 3'd1 && results.ready);
    assign advance       = item_valid_reg && ((res_n == '0) || slot_free);
    assign items.ready   = !item_valid_reg || advance;

    assign results.valid      = (left_reg != '0);
    assign results.out_symbol = slot_reg[0];
    assign results.run_last   = (left_reg == 3'd1);
    assign results.error      = err_reg;

    // process the registered item
    always_comb
    begin
        n              = {1'b0, count_reg} + 3'd1;
        res_n          = '0;
        res_err        = 1'b0;
        count_next     = n[b64_pkg::CntW-1:0];
        third_pad_next = third_pad_reg;
        shifted        = '0;
        enc_t          = '0;
        bits_next      = bits_reg;
        for (int i = 0; i < b64_pkg::MaxRes; i++)
        begin
            res_sym[i] = '0;
        end

        if (mode_reg == b64_pkg::MODE_ENCODE)
        begin
            shifted   = {bits_reg[15:0], sym_reg};
            bits_next = shifted;
            case (n)
                3'd1:    enc_t = {shifted[7:0], 16'h0000};
                3'd2:    enc_t = {shifted[15:0], 8'h00};
                default: enc_t = shifted;
            endcase
            if (n >= 3'd3 || last_reg)
            begin
                res_n      = 3'd4;
                res_sym[0] = b64_pkg::sextet_to_char(enc_t[23:18]);
                res_sym[1] = b64_pkg::sextet_to_char(enc_t[17:12]);
                res_sym[2] = (n >= 3'd2) ? b64_pkg::sextet_to_char(enc_t[11:6])
                                         : b64_pkg::PadChar;
                res_sym[3] = (n >= 3'd3) ? b64_pkg::sextet_to_char(enc_t[5:0])
                                         : b64_pkg::PadChar;
            end
        end
        else
        begin
            shifted   = {bits_reg[17:0], b64_pkg::char_to_sextet(sym_reg)};
            bits_next = shifted;
            if (n == 3'd3)
            begin
                third_pad_next = (sym_reg == b64_pkg::PadChar);
            end
            if (n == 3'd4)
            begin
                res_n = 3'd3;
                if (last_reg)
                begin
                    res_n = 3'd3 - {2'b00, sym_reg == b64_pkg::PadChar}
                                 - {2'b00, third_pad_reg};
                end
                res_sym[0] = shifted[23:16];
                res_sym[1] = shifted[15:8];
                res_sym[2] = shifted[7:0];
            end
            else if (last_reg)
            begin
                res_n   = 3'd1;
                res_err = 1'b1;
            end
        end

        // clear the group once it emits or the stream ends
        if (res_n != '0 || last_reg)
        begin
            count_next     = '0;
            bits_next      = '0;
            third_pad_next = 1'b0;
        end
    end

    // hold control state and codec state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            mode_reg       <= b64_pkg::MODE_ENCODE;
            count_reg      <= '0;
            bits_reg       <= '0;
            third_pad_reg  <= 1'b0;
            left_reg       <= '0;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (items.valid && items.ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (cfg_take)
            begin
                mode_reg      <= b64_pkg::mode_t'(cfg.data);
                count_reg     <= '0;
                bits_reg      <= '0;
                third_pad_reg <= 1'b0;
            end
            else if (advance)
            begin
                count_reg     <= count_next;
                bits_reg      <= bits_next;
                third_pad_reg <= third_pad_next;
            end

            if (advance && res_n != '0)
            begin
                left_reg <= res_n;
                err_reg  <= res_err;
            end
            else if (out_take)
            begin
                left_reg <= left_reg - 3'd1;
            end
        end
    end

    // load or advance the payload registers
    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            sym_reg  <= items.symbol;
            last_reg <= items.last;
        end

        if (advance && res_n != '0)
        begin
            for (int i = 0; i < b64_pkg::MaxRes; i++)
            begin
                slot_reg[i] <= res_sym[i];
            end
        end
        else if (out_take)
        begin
            for (int i = 0; i < b64_pkg::MaxRes - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
            slot_reg[b64_pkg::MaxRes-1] <= '0;
        end
    end

endmodule

`default_nettype wire

### tb/base64_codec_tb.sv
// ----------------------------------------------------------------------------
// base64_codec_tb
// Self-checking bench for the Base64 codec. A tracker class mirrors the codec
// state and queues the result words that each accepted input word causes.
// Every accepted result is checked field by field against that queue. The
// run opens with short directed streams in both modes: pad patterns, stray
// characters, short decode streams and a mode change mid-group. Random
// streams follow under three handshake idling profiles.
// ----------------------------------------------------------------------------

module base64_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 8;
    localparam int PhaseWords  = 20;

    typedef struct packed
    {
        logic [b64_pkg::SymW-1:0] sym;
        logic                     run_last;
        logic                     err;
    } out_word_t;

    // Mirror of the codec: mode, partial group and the result words still due
    class b64_tracker;
        b64_pkg::mode_t             mode;
        logic [b64_pkg::CntW-1:0]   grp_cnt;
        logic [b64_pkg::GroupW-1:0] grp_bits;
        logic                       third_pad;
        out_word_t                  due_q[$];
        int                         n_errs;
        int                         n_checked;

        function new();
            mode      = b64_pkg::MODE_ENCODE;
            grp_cnt   = '0;
            grp_bits  = '0;
            third_pad = 1'b0;
            n_errs    = 0;
            n_checked = 0;
        endfunction

        function void clear_group();
            grp_cnt   = '0;
            grp_bits  = '0;
            third_pad = 1'b0;
        endfunction

        // A mode write abandons any group in progress
        function void set_mode(b64_pkg::mode_t m);
            mode = m;
            clear_group();
        endfunction

        function logic [b64_pkg::SymW-1:0] char_of(logic [b64_pkg::SextW-1:0] v);
            string abc;
            abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            return abc[v];
        endfunction

        // Anything outside the alphabet, pad included, maps to zero
        function logic [b64_pkg::SextW-1:0] sextet_of(logic [b64_pkg::SymW-1:0] c);
            for (int i = 0; i < 64; i++)
            begin
                if (char_of(b64_pkg::SextW'(i)) == c)
                    return b64_pkg::SextW'(i);
            end
            return '0;
        endfunction

        function void push(logic [b64_pkg::SymW-1:0] s, logic rl, logic e);
            out_word_t w;
            w.sym      = s;
            w.run_last = rl;
            w.err      = e;
            due_q = {due_q, w};
        endfunction

        // Advance the mirror by one accepted input word
        function void absorb_word(logic [b64_pkg::SymW-1:0] s, logic l);
            int                         n;
            int                         used;
            int                         k;
            logic [b64_pkg::GroupW-1:0] t;
            n = int'(grp_cnt) + 1;
            if (mode == b64_pkg::MODE_ENCODE)
            begin
                grp_bits = {grp_bits[b64_pkg::GroupW-b64_pkg::SymW-1:0], s};
                if (n >= 3 || l)
                begin
                    // left-align a short group, then pad the missing sextets
                    used = (n >= 3) ? 3 : n;
                    t = grp_bits << (8 * (3 - used));
                    push(char_of(t[23:18]), 1'b0, 1'b0);
                    push(char_of(t[17:12]), 1'b0, 1'b0);
                    push(used >= 2 ? char_of(t[11:6]) : b64_pkg::PadChar, 1'b0, 1'b0);
                    push(used >= 3 ? char_of(t[5:0]) : b64_pkg::PadChar, 1'b1, 1'b0);
                    clear_group();
                end
                else
                begin
                    grp_cnt = b64_pkg::CntW'(n);
                end
                return;
            end

            grp_bits = {grp_bits[b64_pkg::GroupW-b64_pkg::SextW-1:0], sextet_of(s)};
            if (n == 3)
                third_pad = (s == b64_pkg::PadChar);
            if (n >= 4)
            begin
                // trim the final group by its pads, each counted on its own
                k = 3;
                if (l)
                begin
                    if (s == b64_pkg::PadChar)
                        k--;
                    if (third_pad)
                        k--;
                end
                for (int i = 0; i < k; i++)
                    push(grp_bits[b64_pkg::GroupW-1-8*i -: 8], (i + 1 == k), 1'b0);
                clear_group();
            end
            else if (l)
            begin
                // stream ended mid-group
                push('0, 1'b1, 1'b1);
                clear_group();
            end
            else
            begin
                grp_cnt = b64_pkg::CntW'(n);
            end
        endfunction

        // Compare one accepted result word with the oldest one due
        function void check_word(logic [b64_pkg::SymW-1:0] s, logic rl, logic e);
            out_word_t want;
            if (due_q.size() == 0)
            begin
                $error("result word with nothing due: out_symbol %h run_last %b error %b",
                       s, rl, e);
                n_errs++;
                return;
            end
            want = due_q.pop_front();
            n_checked++;
            if (s !== want.sym)
            begin
                $error("out_symbol: expected %h, got %h", want.sym, s);
                n_errs++;
            end
            if (rl !== want.run_last)
            begin
                $error("run_last: expected %b, got %b", want.run_last, rl);
                n_errs++;
            end
            if (e !== want.err)
            begin
                $error("error: expected %b, got %b", want.err, e);
                n_errs++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    b64_cfg_if    cfg_ch ();
    b64_item_if   item_ch ();
    b64_result_if res_ch ();

    b64_tracker codec_sb;

    int tx_idle;
    int rx_idle;
    int n_items;
    int n_enc_streams;
    int n_dec_streams;
    int cycles;

    base64_codec dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .items   (item_ch),
        .results (res_ch)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CycleLimit)
            begin
                $display("base64_codec_tb: done, errors");
                $finish;
            end
        end
    end

    // Result side: check accepted words, then pick ready for the next cycle
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                codec_sb.check_word(res_ch.out_symbol, res_ch.run_last, res_ch.error);
            res_ch.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Offer one word, holding it until accepted
    task automatic send_word(logic [b64_pkg::SymW-1:0] s, logic l);
        while ($urandom_range(99) < tx_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.symbol <= s;
        item_ch.last   <= l;
        do
            @(posedge clk);
        while (!item_ch.ready);
        codec_sb.absorb_word(s, l);
        n_items++;
    endtask

    task automatic send_text(string txt, bit close);
        for (int i = 0; i < txt.len(); i++)
            send_word(txt[i], close && (i == txt.len() - 1));
    endtask

    // Drop valid and wait until nothing is due and the pipeline has emptied
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (codec_sb.due_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic change_mode(b64_pkg::mode_t m);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        codec_sb.set_mode(m);
    endtask

    task automatic encode_stream();
        int len;
        len = ($urandom_range(7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
        for (int i = 0; i < len; i++)
            send_word(b64_pkg::SymW'($urandom_range(255)), i == len - 1);
        n_enc_streams++;
    endtask

    // Mostly well-formed text, some short streams, some raw noise
    task automatic decode_stream();
        int                        kind;
        int                        len;
        int                        groups;
        int                        pat;
        logic [b64_pkg::SymW-1:0]  c;
        bit                        fin;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            groups = $urandom_range(1, 3);
            pat = $urandom_range(3);
            for (int g = 0; g < groups; g++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    fin = (g == groups - 1);
                    c = codec_sb.char_of(b64_pkg::SextW'($urandom_range(63)));
                    if ($urandom_range(19) == 0)
                        c = b64_pkg::PadChar;
                    if (fin && j == 3 && (pat == 1 || pat == 2))
                        c = b64_pkg::PadChar;
                    if (fin && j == 2 && (pat == 2 || pat == 3))
                        c = b64_pkg::PadChar;
                    send_word(c, fin && j == 3);
                end
            end
        end
        else if (kind < 85)
        begin
            len = $urandom_range(1, 11);
            if (len % 4 == 0)
                len++;
            for (int i = 0; i < len; i++)
            begin
                c = ($urandom_range(9) == 0)
                    ? b64_pkg::PadChar
                    : codec_sb.char_of(b64_pkg::SextW'($urandom_range(63)));
                send_word(c, i == len - 1);
            end
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_word(b64_pkg::SymW'($urandom_range(255)), i == len - 1);
        end
        n_dec_streams++;
    endtask

    // One mode setting with random streams, sometimes left open at the end
    task automatic random_phase(b64_pkg::mode_t m);
        int start;
        int extra;
        change_mode(m);
        start = n_items;
        while (n_items - start < PhaseWords)
        begin
            if (m == b64_pkg::MODE_ENCODE)
                encode_stream();
            else
                decode_stream();
        end
        if ($urandom_range(1) == 1)
        begin
            extra = (m == b64_pkg::MODE_ENCODE) ? $urandom_range(1, 2)
                                                : $urandom_range(1, 3);
            for (int i = 0; i < extra; i++)
                send_word(b64_pkg::SymW'($urandom_range(255)), 1'b0);
        end
    endtask

    initial
    begin
        codec_sb = new();
        n_items = 0;
        n_enc_streams = 0;
        n_dec_streams = 0;
        tx_idle = 11;
        rx_idle = 60;
        rst_n          <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.symbol <= '0;
        item_ch.last   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encode from the reset mode: full group, one and two byte tails
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h01, 1'b0);
        send_word(8'hFE, 1'b1);
        // last on a full group, and the '+' and '/' characters
        send_word(8'hFB, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hBF, 1'b1);
        // leave a group open for the mode write to discard
        send_word(8'h7F, 1'b0);
        change_mode(b64_pkg::MODE_DECODE);

        // Decode: alphabet ends, pad and stray characters mid-stream
        send_text("AZaz", 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(b64_pkg::PadChar, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h7E, 1'b0);
        // final group pad patterns: third only, both, fourth only
        send_text("09=+", 1'b1);
        send_text("/Q==", 1'b1);
        send_text("Az9=", 1'b1);
        // short streams
        send_text("a=", 1'b0);
        send_word(8'h00, 1'b1);
        send_text("B", 1'b1);
        send_text("AB", 1'b0);

        // Random streams under each idling profile
        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                tx_idle = 60;
                rx_idle = 11;
            end
            else if (p == 2)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            random_phase(b64_pkg::MODE_ENCODE);
            random_phase(b64_pkg::MODE_DECODE);
        end

        settle();
        repeat (20) @(posedge clk);
        $display("Sent %0d input words in %0d encode and %0d decode streams;",
                 n_items, n_enc_streams, n_dec_streams);
        $display("%0d results checked over pad patterns, stray characters, short decode",
                 codec_sb.n_checked);
        $display("streams and mode changes.");
        if (codec_sb.n_errs == 0)
            $display("base64_codec_tb: done, clean");
        else
            $display("base64_codec_tb: done, errors");
        $finish;
    end

endmodule
